[src/assert_macros.svh]
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[src/srb_pkg.sv]
`timescale 1ns / 1ps

package srb_pkg;

   localparam int DEFAULT_WINDOW_DEPTH = 16;
   localparam int MAX_RESULTS = 16;
   localparam int SEQ_W = 16;
   localparam int HANDLE_W = 16;
   localparam int STATUS_W = 2;
   localparam int CNT_W = $clog2(MAX_RESULTS + 1);

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_STALE  = 2'd1,
      STATUS_BEYOND = 2'd2
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_READ,
      ST_EMIT
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic latch_in;
      logic store;
      logic clear_count;
      logic release_slot;
      logic load_err;
      logic load_ok;
      logic last;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic in_window;
      logic head_valid;
      logic count_full;
      logic out_free;
   } dp_status_type;

endpackage

[src/srb_if.sv]
`timescale 1ns / 1ps

// completed item channel
interface srb_req_if
   import srb_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [SEQ_W-1:0]    in_seq;
   logic [HANDLE_W-1:0] in_handle;

   modport source (output valid, output in_seq, output in_handle, input ready);
   modport sink   (input valid, input in_seq, input in_handle, output ready);
endinterface

// release and error result channel
interface srb_rsp_if
   import srb_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [HANDLE_W-1:0] out_handle;
   logic [SEQ_W-1:0]    out_seq;
   logic [STATUS_W-1:0] out_status;
   logic                run_last;

   modport source (output valid, output out_handle, output out_seq, output out_status,
                   output run_last, input ready);
   modport sink   (input valid, input out_handle, input out_seq, input out_status,
                   input run_last, output ready);
endinterface

[src/srb_ctrl.sv]
`timescale 1ns / 1ps

module srb_ctrl
   import srb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      more;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // another slot can be released in this run
   assign more = status.head_valid && !status.count_full;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            // input stays closed while reset is held
            req_ready = !reset;
            if (req_valid && req_ready) begin
               cmd.latch_in = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.in_window) begin
               if (status.out_free) begin
                  cmd.load_err = 1'b1;
                  cmd.last     = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.store       = 1'b1;
               cmd.clear_count = 1'b1;
               state_in        = ST_READ;
            end
         end
         ST_READ: begin
            if (more) begin
               cmd.release_slot = 1'b1;
               state_in         = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_ok = 1'b1;
               cmd.last    = !more;
               state_in    = more ? ST_READ : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[src/srb_datapath.sv]
`timescale 1ns / 1ps

module srb_datapath
   import srb_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   output dp_status_type       status,
   input  logic [SEQ_W-1:0]    in_seq,
   input  logic [HANDLE_W-1:0] in_handle,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [HANDLE_W-1:0] rsp_handle,
   output logic [SEQ_W-1:0]    rsp_seq,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_last
);

   localparam int IDX_W = $clog2(WINDOW_DEPTH);

   // latched transaction
   logic [SEQ_W-1:0]    in_seq_ff;
   logic [HANDLE_W-1:0] in_handle_ff;

   // window state
   logic [SEQ_W-1:0]        expected_ff, expected_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [WINDOW_DEPTH-1:0] slot_valid_ff, slot_valid_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [HANDLE_W-1:0]     slot_handle_ff [WINDOW_DEPTH];
   logic [HANDLE_W-1:0]     rd_handle_ff;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [HANDLE_W-1:0] rsp_handle_ff;
   logic [SEQ_W-1:0]    rsp_seq_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_last_ff;

   logic [SEQ_W-1:0] seq_gap;
   logic [IDX_W:0]   idx_sum;
   logic [IDX_W-1:0] store_idx;
   logic [IDX_W-1:0] head_next;
   status_type       err_code;

   // distance from the expected sequence and target slot
   assign seq_gap  = in_seq_ff - expected_ff;
   assign idx_sum  = {1'b0, head_ff} + {1'b0, seq_gap[IDX_W-1:0]};
   assign store_idx = (idx_sum >= (IDX_W+1)'(WINDOW_DEPTH))
                      ? IDX_W'(idx_sum - (IDX_W+1)'(WINDOW_DEPTH))
                      : idx_sum[IDX_W-1:0];
   assign head_next = (head_ff == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign err_code  = seq_gap[SEQ_W-1] ? STATUS_STALE : STATUS_BEYOND;

   // status toward the controller
   assign status.in_window  = seq_gap < SEQ_W'(WINDOW_DEPTH);
   assign status.head_valid = slot_valid_ff[head_ff];
   assign status.count_full = count_ff == CNT_W'(MAX_RESULTS);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   // input capture
   always_ff @(posedge clock) begin
      if (cmd.latch_in) begin
         in_seq_ff    <= in_seq;
         in_handle_ff <= in_handle;
      end
   end

   // window control next values
   always_comb begin
      expected_in   = expected_ff;
      head_in       = head_ff;
      slot_valid_in = slot_valid_ff;
      count_in      = count_ff;
      if (cmd.store) begin
         slot_valid_in[store_idx] = 1'b1;
      end
      if (cmd.clear_count) begin
         count_in = '0;
      end
      if (cmd.release_slot) begin
         slot_valid_in[head_ff] = 1'b0;
         expected_in            = expected_ff + 1'b1;
         head_in                = head_next;
         count_in               = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff   <= '0;
         head_ff       <= '0;
         slot_valid_ff <= '0;
         count_ff      <= '0;
      end else begin
         expected_ff   <= expected_in;
         head_ff       <= head_in;
         slot_valid_ff <= slot_valid_in;
         count_ff      <= count_in;
      end
   end

   // handle memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         slot_handle_ff[store_idx] <= in_handle_ff;
      end
      if (cmd.release_slot) begin
         rd_handle_ff <= slot_handle_ff[head_ff];
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_err || cmd.load_ok) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_err) begin
         rsp_handle_ff <= in_handle_ff;
         rsp_seq_ff    <= in_seq_ff;
         rsp_status_ff <= err_code;
         rsp_last_ff   <= cmd.last;
      end else if (cmd.load_ok) begin
         rsp_handle_ff <= rd_handle_ff;
         rsp_seq_ff    <= expected_ff - 1'b1;
         rsp_status_ff <= STATUS_OK;
         rsp_last_ff   <= cmd.last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_handle = rsp_handle_ff;
   assign rsp_seq    = rsp_seq_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

[src/sequence_reorder_buffer_unit.sv]
// Sequence reorder buffer: completed items tagged with a 16-bit sequence number arrive in any
// order and are held in a window of WINDOW_DEPTH slots; each stored item releases, in order,
// the run of filled slots that starts at the expected sequence, at most 16 results per item,
// with run_last set on the final one. Tags behind the expected sequence (stale) or at least
// WINDOW_DEPTH ahead of it are dropped and reported by one error result. A stored item
// is checked and written to its slot; each release then reads the handle memory through a
// registered read before the result is loaded. A new transaction is taken while a finished
// result still waits on the output. Reset is synchronous and clears the window state at once.
`timescale 1ns / 1ps

module sequence_reorder_buffer_unit
   import srb_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
   input logic clock,
   input logic reset,
   srb_req_if.sink   req_chan,
   srb_rsp_if.source rsp_chan
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencing of store and release steps
   srb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // window slots, handle memory and result register
   srb_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .in_seq     (req_chan.in_seq),
      .in_handle  (req_chan.in_handle),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_handle (rsp_chan.out_handle),
      .rsp_seq    (rsp_chan.out_seq),
      .rsp_status (rsp_chan.out_status),
      .rsp_last   (rsp_chan.run_last)
   );

endmodule

[src/srb_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srb_checker
   import srb_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [HANDLE_W-1:0] rsp_handle,
   input logic [SEQ_W-1:0]    rsp_seq,
   input logic [STATUS_W-1:0] rsp_status,
   input logic                run_last
);

   // output register is empty right after reset
   `ASSERT_IMPLY(a_empty_after_reset, clock, reset, $past(reset), !rsp_valid)

   // an error result always closes its transaction's results
   `ASSERT_IMPLY(a_error_is_last, clock, reset, rsp_valid && (rsp_status != STATUS_OK), run_last)

   // one transaction in flight: input closes after each accepted transaction
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // a stalled result holds its payload
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
                rsp_valid && $stable(rsp_handle) && $stable(rsp_seq) && $stable(rsp_status)
                && $stable(run_last))

endmodule

bind sequence_reorder_buffer_unit srb_checker u_srb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_handle (rsp_chan.out_handle),
   .rsp_seq    (rsp_chan.out_seq),
   .rsp_status (rsp_chan.out_status),
   .run_last   (rsp_chan.run_last)
);
